// File: rtl/segi_pkg.sv
package segi_pkg;

   localparam int TOL_BITS = 20;
   localparam int CSR_INDEX_BITS = 1;
   localparam int NUM_POINTS = 4;
   localparam int NUM_PAIRS = 6;
   localparam int NUM_CROSS = 6;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CROSS_TOL = 1'b0,
      CSR_DIST_TOL  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DEC_ENDPOINT    = 2'd0,
      DEC_ALL_COLIN   = 2'd1,
      DEC_PARTIAL     = 2'd2,
      DEC_ORIENTATION = 2'd3
   } decided_type;

   // points
   localparam int PT_A = 0;
   localparam int PT_B = 1;
   localparam int PT_C = 2;
   localparam int PT_D = 3;

   // point pairs, difference is q - p
   localparam int D_AB = 0;
   localparam int D_AC = 1;
   localparam int D_AD = 2;
   localparam int D_BC = 3;
   localparam int D_BD = 4;
   localparam int D_CD = 5;
   localparam int PAIR_P [NUM_PAIRS] = '{PT_A, PT_A, PT_A, PT_B, PT_B, PT_C};
   localparam int PAIR_Q [NUM_PAIRS] = '{PT_B, PT_C, PT_D, PT_C, PT_D, PT_D};

   // cross = dx[u]*dy[v] - dy[u]*dx[v]
   localparam int X_ABC = 0;
   localparam int X_ABD = 1;
   localparam int X_ACD = 2;
   localparam int X_BCD = 3;
   localparam int X_CAB = 4;
   localparam int X_DAB = 5;
   localparam int CROSS_U [NUM_CROSS] = '{D_AB, D_AB, D_AC, D_BC, D_AC, D_AD};
   localparam int CROSS_V [NUM_CROSS] = '{D_AC, D_AD, D_AD, D_BD, D_BC, D_BD};

   // point-on-segment: segment length, then the two endpoint-to-point distances
   localparam int ON_SEG [NUM_POINTS] = '{D_CD, D_CD, D_AB, D_AB};
   localparam int ON_S1  [NUM_POINTS] = '{D_AC, D_BC, D_AC, D_AD};
   localparam int ON_S2  [NUM_POINTS] = '{D_AD, D_BD, D_BC, D_BD};

   typedef struct packed {
      logic                  ends;
      logic [NUM_POINTS-1:0] same;
      logic [3:0]            colin;  // ABC, ABD, ACD, BCD
      logic [3:0]            ccw;    // ACD, BCD, CAB, DAB
   } side_type;

endpackage

// File: rtl/segi_req_if.sv
interface segi_req_if #(
   parameter int COORD_BITS = 20
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] ax;
   logic signed [COORD_BITS-1:0] ay;
   logic signed [COORD_BITS-1:0] bx;
   logic signed [COORD_BITS-1:0] by_coord;
   logic signed [COORD_BITS-1:0] cx;
   logic signed [COORD_BITS-1:0] cy;
   logic signed [COORD_BITS-1:0] dx;
   logic signed [COORD_BITS-1:0] dy;
   logic                         endpoint_touch;

   modport source (
      output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, endpoint_touch,
      input  ready
   );
   modport sink (
      input  valid, ax, ay, bx, by_coord, cx, cy, dx, dy, endpoint_touch,
      output ready
   );
endinterface

// File: rtl/segi_rsp_if.sv
interface segi_rsp_if;
   logic       valid;
   logic       ready;
   logic       intersects;
   logic [1:0] decided_by;

   modport source (output valid, intersects, decided_by, input ready);
   modport sink (input valid, intersects, decided_by, output ready);
endinterface

// File: rtl/segi_sqrt.sv
module segi_sqrt #(
   parameter int RootBits = 21,
   parameter int StepBits = 2
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*RootBits-1:0] rad_i,
   output logic [RootBits-1:0]   root_o
);

   localparam int NB  = 2 * RootBits;
   localparam int RMB = RootBits + 2;
   localparam int TB  = RMB + 2;
   localparam int NST = (RootBits + StepBits - 1) / StepBits;

   logic [NB-1:0]       rad_ff  [NST];
   logic [RMB-1:0]      rem_ff  [NST];
   logic [RootBits-1:0] root_ff [NST];
   logic [NB-1:0]       rad_in  [NST];
   logic [RMB-1:0]      rem_in  [NST];
   logic [RootBits-1:0] root_in [NST];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      always_comb begin
         logic [NB-1:0]       r_rad;
         logic [RMB-1:0]      r_rem;
         logic [RootBits-1:0] r_root;
         logic [TB-1:0]       t;
         logic [TB-1:0]       trial;
         if (s == 0) begin
            r_rad  = rad_i;
            r_rem  = '0;
            r_root = '0;
         end else begin
            r_rad  = rad_ff[s-1];
            r_rem  = rem_ff[s-1];
            r_root = root_ff[s-1];
         end
         for (int j = 0; j < StepBits; j++) begin
            if (s * StepBits + j < RootBits) begin
               t     = {r_rem, r_rad[NB-1 -: 2]};
               trial = {{(TB-RootBits-2){1'b0}}, r_root, 2'b01};
               if (t >= trial) begin
                  r_rem  = RMB'(t - trial);
                  r_root = {r_root[RootBits-2:0], 1'b1};
               end else begin
                  r_rem  = RMB'(t);
                  r_root = {r_root[RootBits-2:0], 1'b0};
               end
               r_rad = {r_rad[NB-3:0], 2'b00};
            end
         end
         rad_in[s]  = r_rad;
         rem_in[s]  = r_rem;
         root_in[s] = r_root;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= rad_in[s];
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign root_o = root_ff[NST-1];

endmodule

// File: rtl/segment_pair_intersection_test.sv
// Two-segment intersection test, fully pipelined.
//
// req carries segments AB and CD (signed fixed-point coordinates) and the
// endpoint_touch flag; rsp returns intersects and decided_by. Both are
// valid/ready channels; a transfer happens when valid and ready are high
// at a rising clock edge.
// The csr port writes cross_tolerance (index 0) and distance_tolerance
// (index 1); write only while no transfer is in flight.
//
// The pipeline depth from request transfer to response valid is set by
// the floor-sqrt units, which resolve two root bits per stage.
// Throughput: one pair per cycle. The whole pipeline advances together;
// req.ready is high whenever the response register is empty or drained.
// A stalled receiver holds the pipeline; nothing is dropped or repeated.
// Reset (synchronous) clears all valid bits and sets both tolerances to 1.
module segment_pair_intersection_test #(
   parameter int COORD_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   segi_req_if.sink                             req,
   segi_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  logic [segi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [segi_pkg::TOL_BITS-1:0]        csr_write_data
);

   localparam int TOLB  = segi_pkg::TOL_BITS;
   localparam int DW    = COORD_BITS + 1;
   localparam int PW    = 2 * DW;
   localparam int XW    = PW + 1;
   localparam int RW    = COORD_BITS + 1;
   localparam int SQW   = 2 * RW;
   localparam int STEP  = 2;
   localparam int NST   = (RW + STEP - 1) / STEP;
   localparam int DEPTH = NST + 5;
   localparam int XCW   = ((XW > TOLB) ? XW : TOLB) + 1;
   localparam int ECW   = ((RW + 2 > TOLB) ? RW + 2 : TOLB) + 1;
   localparam int NP    = segi_pkg::NUM_PAIRS;
   localparam int NX    = segi_pkg::NUM_CROSS;
   localparam int NPT   = segi_pkg::NUM_POINTS;

   logic [TOLB-1:0]  ctol_ff;
   logic [TOLB-1:0]  dtol_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctol_ff <= TOLB'(1);
         dtol_ff <= TOLB'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            segi_pkg::CSR_CROSS_TOL: ctol_ff <= csr_write_data;
            segi_pkg::CSR_DIST_TOL:  dtol_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign en        = !valid_ff[DEPTH-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req.valid};
      end
   end

   // stage A: coordinate differences and exact matches
   logic signed [COORD_BITS-1:0] px [NPT];
   logic signed [COORD_BITS-1:0] py [NPT];
   logic signed [DW-1:0]         dxa_in [NP];
   logic signed [DW-1:0]         dya_in [NP];
   logic signed [DW-1:0]         dxa_ff [NP];
   logic signed [DW-1:0]         dya_ff [NP];
   segi_pkg::side_type           sa_in;
   segi_pkg::side_type           sa_ff;

   assign px[segi_pkg::PT_A] = req.ax;
   assign py[segi_pkg::PT_A] = req.ay;
   assign px[segi_pkg::PT_B] = req.bx;
   assign py[segi_pkg::PT_B] = req.by_coord;
   assign px[segi_pkg::PT_C] = req.cx;
   assign py[segi_pkg::PT_C] = req.cy;
   assign px[segi_pkg::PT_D] = req.dx;
   assign py[segi_pkg::PT_D] = req.dy;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         dxa_in[k] = DW'(px[segi_pkg::PAIR_Q[k]]) - DW'(px[segi_pkg::PAIR_P[k]]);
         dya_in[k] = DW'(py[segi_pkg::PAIR_Q[k]]) - DW'(py[segi_pkg::PAIR_P[k]]);
      end
      sa_in       = '0;
      sa_in.ends  = req.endpoint_touch;
      for (int t = 0; t < NPT; t++) begin
         sa_in.same[t] =
            (dxa_in[segi_pkg::ON_S1[t]] == '0 && dya_in[segi_pkg::ON_S1[t]] == '0) ||
            (dxa_in[segi_pkg::ON_S2[t]] == '0 && dya_in[segi_pkg::ON_S2[t]] == '0);
      end
   end

   // stage B: squares and cross-product terms
   logic signed [PW-1:0] sqx_in [NP];
   logic signed [PW-1:0] sqy_in [NP];
   logic signed [PW-1:0] pa_in  [NX];
   logic signed [PW-1:0] pb_in  [NX];
   logic signed [PW-1:0] sqx_ff [NP];
   logic signed [PW-1:0] sqy_ff [NP];
   logic signed [PW-1:0] pa_ff  [NX];
   logic signed [PW-1:0] pb_ff  [NX];
   segi_pkg::side_type   sb_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         sqx_in[k] = dxa_ff[k] * dxa_ff[k];
         sqy_in[k] = dya_ff[k] * dya_ff[k];
      end
      for (int j = 0; j < NX; j++) begin
         pa_in[j] = dxa_ff[segi_pkg::CROSS_U[j]] * dya_ff[segi_pkg::CROSS_V[j]];
         pb_in[j] = dya_ff[segi_pkg::CROSS_U[j]] * dxa_ff[segi_pkg::CROSS_V[j]];
      end
   end

   // stage C: squared lengths and cross products
   logic [SQW-1:0]       rad_in   [NP];
   logic [SQW-1:0]       rad_ff   [NP];
   logic signed [XW-1:0] cross_in [NX];
   logic signed [XW-1:0] cross_ff [NX];
   segi_pkg::side_type   sc_ff;

   always_comb begin
      for (int k = 0; k < NP; k++) begin
         rad_in[k] = SQW'(unsigned'(sqx_ff[k])) + SQW'(unsigned'(sqy_ff[k]));
      end
      for (int j = 0; j < NX; j++) begin
         cross_in[j] = XW'(pa_ff[j]) - XW'(pb_ff[j]);
      end
   end

   // tolerance tests on the cross products, run beside the sqrt pipeline
   segi_pkg::side_type side0_in;
   segi_pkg::side_type side_ff [NST];

   always_comb begin
      logic signed [XCW-1:0] xe;
      logic signed [XCW-1:0] xa;
      logic signed [XCW-1:0] te;
      te       = XCW'(signed'({1'b0, ctol_ff}));
      side0_in = sc_ff;
      for (int j = 0; j < NX; j++) begin
         xe = XCW'(cross_ff[j]);
         xa = (xe < 0) ? -xe : xe;
         if (j < 4) begin
            side0_in.colin[j] = xa < te;
         end
         if (j >= 2) begin
            side0_in.ccw[j-2] = xe > te;
         end
      end
   end

   logic [RW-1:0] dist_w [NP];

   for (genvar k = 0; k < NP; k++) begin : g_dist
      segi_sqrt #(
         .RootBits (RW),
         .StepBits (STEP)
      ) u_sqrt (
         .clock  (clock),
         .en     (en),
         .rad_i  (rad_ff[k]),
         .root_o (dist_w[k])
      );
   end

   // stage E: point-on-segment distance tests
   logic [NPT-1:0]     near_in;
   logic [NPT-1:0]     near_ff;
   segi_pkg::side_type se_ff;

   always_comb begin
      logic signed [ECW-1:0] de;
      logic signed [ECW-1:0] dm;
      logic signed [ECW-1:0] te;
      te = ECW'(signed'({1'b0, dtol_ff}));
      for (int t = 0; t < NPT; t++) begin
         de = ECW'(signed'({1'b0, dist_w[segi_pkg::ON_SEG[t]]}))
            - ECW'(signed'({1'b0, dist_w[segi_pkg::ON_S1[t]]}))
            - ECW'(signed'({1'b0, dist_w[segi_pkg::ON_S2[t]]}));
         dm = (de < 0) ? -de : de;
         near_in[t] = dm < te;
      end
   end

   // stage F: decision
   logic                  hit_in;
   segi_pkg::decided_type how_in;
   logic                  hit_ff;
   segi_pkg::decided_type how_ff;

   always_comb begin
      if (se_ff.ends && |(se_ff.same | near_ff)) begin
         hit_in = 1'b1;
         how_in = segi_pkg::DEC_ENDPOINT;
      end else if (&se_ff.colin) begin
         hit_in = |(near_ff & ~se_ff.same);
         how_in = segi_pkg::DEC_ALL_COLIN;
      end else if (|se_ff.colin) begin
         hit_in = 1'b0;
         how_in = segi_pkg::DEC_PARTIAL;
      end else begin
         hit_in = (se_ff.ccw[0] != se_ff.ccw[1]) && (se_ff.ccw[2] != se_ff.ccw[3]);
         how_in = segi_pkg::DEC_ORIENTATION;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dxa_ff <= dxa_in;
         dya_ff <= dya_in;
         sa_ff  <= sa_in;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         sb_ff  <= sa_ff;
         rad_ff   <= rad_in;
         cross_ff <= cross_in;
         sc_ff    <= sb_ff;
         side_ff[0] <= side0_in;
         for (int i = 1; i < NST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         near_ff <= near_in;
         se_ff   <= side_ff[NST-1];
         hit_ff  <= hit_in;
         how_ff  <= how_in;
      end
   end

   assign rsp.valid      = valid_ff[DEPTH-1];
   assign rsp.intersects = hit_ff;
   assign rsp.decided_by = how_ff;

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready does not follow the output register state");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> valid_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_endpoint_hit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.decided_by == segi_pkg::DEC_ENDPOINT |-> rsp.intersects)
      else $error("endpoint decision without a hit");

   a_partial_miss: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.decided_by == segi_pkg::DEC_PARTIAL |-> !rsp.intersects)
      else $error("partial colinear decision reported a hit");

endmodule
